[hw/rtl/edt_pkg.sv]
package edt_pkg;

	// Table geometry and coordinate format
	localparam int MAX_POINTS   = 64;
	localparam int COORD_BITS   = 16;

	// Port widths fixed by the interface
	localparam int IDX_W        = 6;
	localparam int PORT_COORD_W = 16;
	localparam int DIST_W       = 17;

	// Derived widths
	localparam int ADDR_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int EXT_W    = IDX_W + ADDR_W;
	localparam int DIFF_W   = COORD_BITS + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int SUM_W    = SQ_W + 1;
	localparam int ROOT_W   = (SUM_W + 1) / 2;
	localparam int WORD_W   = 2 * COORD_BITS;
	localparam int SAT_W    = ROOT_W + DIST_W;

	// Command queue between front and back
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [SUM_W-1:0]  ROOT_BIT_INIT =
		{{(SUM_W-1){1'b0}}, 1'b1} << (2 * (ROOT_W - 1));

	typedef struct packed {
		logic                         is_query;
		logic                         same_idx;
		logic                         a_ok;
		logic                         b_ok;
		logic [ADDR_W-1:0]            addr_a;
		logic [ADDR_W-1:0]            addr_b;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} cmd_t;

	function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
		logic [EXT_W-1:0] e;
		e = {{ADDR_W{1'b0}}, idx};
		return e < EXT_W'(MAX_POINTS);
	endfunction

	function automatic logic [ADDR_W-1:0] idx_addr(input logic [IDX_W-1:0] idx);
		logic [EXT_W-1:0] e;
		e = {{ADDR_W{1'b0}}, idx};
		return e[ADDR_W-1:0];
	endfunction

	// Keep the low COORD_BITS of a port value as two's complement
	function automatic logic signed [COORD_BITS-1:0] to_coord(
		input logic [PORT_COORD_W-1:0] v);
		logic [PORT_COORD_W+COORD_BITS-1:0] w;
		w = {{COORD_BITS{1'b0}}, v};
		return w[COORD_BITS-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] sat_dist(input logic [ROOT_W-1:0] r);
		logic [SAT_W-1:0] e;
		e = {{DIST_W{1'b0}}, r};
		if (e > SAT_W'(DIST_MAX)) begin
			return DIST_MAX;
		end
		return e[DIST_W-1:0];
	endfunction

endpackage

[hw/rtl/edt_front.sv]
module edt_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               mode,
	input  logic [edt_pkg::IDX_W-1:0]          first_index,
	input  logic [edt_pkg::IDX_W-1:0]          second_index,
	input  logic signed [edt_pkg::PORT_COORD_W-1:0] coord_x,
	input  logic signed [edt_pkg::PORT_COORD_W-1:0] coord_y,
	output logic                               cmd_valid,
	output edt_pkg::cmd_t                      cmd,
	input  logic                               cmd_pop
);
	import edt_pkg::*;

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	cmd_t              cmd_in;
	logic              do_push;
	logic              do_pop;

	// classify on the way in
	always_comb begin
		cmd_in.is_query = mode;
		cmd_in.same_idx = (first_index == second_index);
		cmd_in.a_ok     = idx_ok(first_index);
		cmd_in.b_ok     = idx_ok(second_index);
		cmd_in.addr_a   = idx_addr(first_index);
		cmd_in.addr_b   = idx_addr(second_index);
		cmd_in.x        = to_coord(coord_x);
		cmd_in.y        = to_coord(coord_y);
	end

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = ent_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/edt_sqrt.sv]
module edt_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [edt_pkg::SUM_W-1:0]   radicand,
	output logic                        done,
	output logic [edt_pkg::ROOT_W-1:0]  root
);
	import edt_pkg::*;

	logic             busy_q;
	logic [SUM_W-1:0] n_q;
	logic [SUM_W-1:0] root_q;
	logic [SUM_W-1:0] bit_q;
	logic [SUM_W:0]   trial;
	logic             take;

	// one result bit per cycle, restoring form
	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = ({1'b0, n_q} >= trial);
	assign done  = busy_q && bit_q[0];
	assign root  = root_q[ROOT_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= radicand;
			root_q <= '0;
			bit_q  <= ROOT_BIT_INIT;
		end else if (busy_q) begin
			if (take) begin
				n_q    <= n_q - trial[SUM_W-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

endmodule

[hw/rtl/edt_back.sv]
module edt_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  edt_pkg::cmd_t               cmd,
	output logic                        cmd_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [edt_pkg::DIST_W-1:0]  distance
);
	import edt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_SQX,
		S_SQY,
		S_ROOT,
		S_OUT
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	logic [DIST_W-1:0]   distance_q;

	logic [WORD_W-1:0]   mem_q [MAX_POINTS];
	logic [WORD_W-1:0]   rd_a_s1;
	logic [WORD_W-1:0]   rd_b_s1;
	logic                a_ok_s1;
	logic                b_ok_s1;
	logic                zero_q;
	logic [DIFF_W-1:0]   dx_q;
	logic [DIFF_W-1:0]   dy_q;
	logic [SQ_W-1:0]     sum_q;

	logic [COORD_BITS-1:0] xa, ya, xb, yb;
	logic [DIFF_W-1:0]   ddx, ddy;
	logic [DIFF_W-1:0]   adx, ady;
	logic [SQ_W-1:0]     sqx, sqy;
	logic [SUM_W-1:0]    radicand;
	logic                sq_start;
	logic                sq_done;
	logic [ROOT_W-1:0]   sq_root;
	logic                out_free;

	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign empty    = !out_valid_q;
	assign distance = distance_q;
	assign out_free = !out_valid_q || pop;

	// point table: x in the upper half of a word
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			if (!cmd.is_query && cmd.a_ok) begin
				mem_q[cmd.addr_a] <= {cmd.x, cmd.y};
			end
			rd_a_s1 <= mem_q[cmd.addr_a];
			rd_b_s1 <= mem_q[cmd.addr_b];
			a_ok_s1 <= cmd.a_ok;
			b_ok_s1 <= cmd.b_ok;
			zero_q  <= cmd.same_idx;
		end
	end

	// out-of-range points read as the origin
	assign xa = a_ok_s1 ? rd_a_s1[WORD_W-1:COORD_BITS] : '0;
	assign ya = a_ok_s1 ? rd_a_s1[COORD_BITS-1:0]      : '0;
	assign xb = b_ok_s1 ? rd_b_s1[WORD_W-1:COORD_BITS] : '0;
	assign yb = b_ok_s1 ? rd_b_s1[COORD_BITS-1:0]      : '0;

	assign ddx = {xa[COORD_BITS-1], xa} - {xb[COORD_BITS-1], xb};
	assign ddy = {ya[COORD_BITS-1], ya} - {yb[COORD_BITS-1], yb};
	assign adx = ddx[DIFF_W-1] ? (~ddx + 1'b1) : ddx;
	assign ady = ddy[DIFF_W-1] ? (~ddy + 1'b1) : ddy;

	assign sqx      = dx_q * dx_q;
	assign sqy      = dy_q * dy_q;
	assign radicand = {1'b0, sum_q} + {1'b0, sqy};
	assign sq_start = (state_q == S_SQY);

	always_ff @(posedge clk) begin
		if (state_q == S_DIFF) begin
			dx_q <= adx;
			dy_q <= ady;
		end
		if (state_q == S_SQX) begin
			sum_q <= sqx;
		end
	end

	edt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			distance_q  <= '0;
		end else begin
			// a new result may replace the one popped in the same cycle
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd.is_query) begin
						state_q <= cmd.same_idx ? S_OUT : S_DIFF;
					end
				end
				S_DIFF: state_q <= S_SQX;
				S_SQX:  state_q <= S_SQY;
				S_SQY:  state_q <= S_ROOT;
				S_ROOT: begin
					if (sq_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						distance_q <= zero_q ? '0 : sat_dist(sq_root);
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(distance_q))
		else $error("waiting result lost or changed");

	a_root_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == S_ROOT)
		else $error("root finished outside root state");

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && cmd.is_query |=> state_q == S_DIFF || state_q == S_OUT)
		else $error("query popped but not started");
`endif

endmodule

[hw/rtl/euclidean_distance_table.sv]
// Load beat: enters the table when the back end pops it; one per cycle (back end idle).
// Query beat: the back end takes no further command until the result is registered;
//   the root comes from the one-bit-per-cycle square root unit.
// Query of a point with itself: skips the arithmetic and goes straight to the result state.
// Reset (arst_n low, asynchronous): command queue and result register empty; table contents
//   undefined until loaded.
module euclidean_distance_table (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// input beats
	input  logic                                    push,
	output logic                                    full,
	input  logic                                    mode,
	input  logic [edt_pkg::IDX_W-1:0]               first_index,
	input  logic [edt_pkg::IDX_W-1:0]               second_index,
	input  logic signed [edt_pkg::PORT_COORD_W-1:0] coord_x,
	input  logic signed [edt_pkg::PORT_COORD_W-1:0] coord_y,
	// result beats
	output logic                                    empty,
	input  logic                                    pop,
	output logic [edt_pkg::DIST_W-1:0]              distance
);
	import edt_pkg::*;

	// Front end: takes beats, decodes mode and indexes, and parks them in a
	// short command queue so input waits on the arithmetic only when it is full.
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	edt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.first_index  (first_index),
		.second_index (second_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	// Back end: owns the point table, runs commands in order. Loads retire as
	// they are popped; queries read both points, take |dx| and |dy|, square and
	// sum in the S_SQX and S_SQY states, then hand the sum to the iterative root
	// unit. The result register lets a finished distance wait for pop.
	edt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.distance  (distance)
	);

endmodule

[tb/tb_euclidean_distance_table.sv]
module tb_euclidean_distance_table;
	import edt_pkg::*;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// cycles with neither an input nor a result beat before the run is called hung
	localparam int STALL_LIMIT  = 4000;
	// drain time after the last result
	localparam int DRAIN_CYCLES = 60;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                           push         = 1'b0;
	logic                           full;
	logic                           mode         = MODE_LOAD;
	logic [IDX_W-1:0]               first_index  = '0;
	logic [IDX_W-1:0]               second_index = '0;
	logic signed [PORT_COORD_W-1:0] coord_x      = '0;
	logic signed [PORT_COORD_W-1:0] coord_y      = '0;
	logic                           empty;
	logic                           pop          = 1'b0;
	logic [DIST_W-1:0]              distance;

	euclidean_distance_table u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.first_index  (first_index),
		.second_index (second_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.empty        (empty),
		.pop          (pop),
		.distance     (distance)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the point table. pt_loaded keeps every query on entries
	// that were written since reset; reading an unwritten entry is illegal.
	logic signed [PORT_COORD_W-1:0] pt_x [MAX_POINTS];
	logic signed [PORT_COORD_W-1:0] pt_y [MAX_POINTS];
	bit                             pt_loaded [MAX_POINTS];
	logic [IDX_W-1:0]               last_loaded;

	logic [DIST_W-1:0] dist_expected [$];
	int                mismatches  = 0;
	int                idle_cycles = 0;
	bit                calm        = 1'b0;	// no new gaps on either side while set
	int                pop_hold    = 0;

	wire in_beat  = push && !full;
	wire out_beat = pop && !empty;

	// Gap length in cycles: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 60);
	endfunction

	// floor(sqrt(n)) by trial of each root bit, msb first
	function automatic logic [DIST_W-1:0] floor_root(input longint unsigned n);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 20; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= n) begin
				root = trial;
			end
		end
		if (root > DIST_MAX) begin
			return DIST_MAX;
		end
		return root[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] predict_distance(input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b);
		longint dx;
		longint dy;
		if (a == b) begin
			return '0;
		end
		dx = longint'(pt_x[a]) - longint'(pt_x[b]);
		dy = longint'(pt_y[a]) - longint'(pt_y[b]);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return floor_root(longint'(dx * dx + dy * dy));
	endfunction

	// Drive one beat at the falling edge, hold it until accepted, then update
	// the shadow table or queue the expected distance. push stays high when
	// no gap follows, so back-to-back beats never toggle it.
	task automatic send_beat(input logic m, input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b, input logic signed [PORT_COORD_W-1:0] x,
		input logic signed [PORT_COORD_W-1:0] y);
		int gap;
		@(negedge clk);
		mode         <= m;
		first_index  <= a;
		second_index <= b;
		coord_x      <= x;
		coord_y      <= y;
		push         <= 1'b1;
		do @(posedge clk); while (full);
		if (m == MODE_LOAD) begin
			pt_x[a]      = x;
			pt_y[a]      = y;
			pt_loaded[a] = 1'b1;
			last_loaded  = a;
		end else begin
			dist_expected.insert(dist_expected.size(), predict_distance(a, b));
		end
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic load_point(input int a, input int x, input int y);
		// second_index is a don't-care on loads; keep it moving
		send_beat(MODE_LOAD, IDX_W'(a), IDX_W'($urandom), PORT_COORD_W'(x),
			PORT_COORD_W'(y));
	endtask

	task automatic query_pair(input int a, input int b);
		// coordinates are don't-cares on queries
		send_beat(MODE_QUERY, IDX_W'(a), IDX_W'(b), PORT_COORD_W'($urandom),
			PORT_COORD_W'($urandom));
	endtask

	function automatic logic [IDX_W-1:0] pick_loaded();
		logic [IDX_W-1:0] k;
		k = IDX_W'($urandom);
		while (!pt_loaded[k]) begin
			k = IDX_W'($urandom);
		end
		return k;
	endfunction

	function automatic logic signed [PORT_COORD_W-1:0] pick_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return PORT_COORD_W'($urandom);
		end
		if (r < 7) begin
			case ($urandom_range(0, 4))
				0: return {1'b1, {(PORT_COORD_W-1){1'b0}}};
				1: return {1'b0, {(PORT_COORD_W-1){1'b1}}};
				2: return '0;
				3: return '1;
				default: return PORT_COORD_W'(1);
			endcase
		end
		// small values give exact squares and near-miss roots
		return PORT_COORD_W'($urandom_range(0, 16)) - PORT_COORD_W'(8);
	endfunction

	// Opposite corners of the coordinate range: largest possible distance,
	// full-span single-axis distances.
	task automatic test_corner_points();
		load_point(0, -32768, -32768);
		load_point(63, 32767, 32767);
		query_pair(0, 63);
		query_pair(63, 0);
		load_point(1, 32767, -32768);
		load_point(62, -32768, 32767);
		query_pair(1, 62);
		query_pair(0, 1);
		query_pair(0, 62);
	endtask

	// Point against itself, and two distinct entries holding the same point.
	task automatic test_self_and_overlap();
		query_pair(0, 0);
		query_pair(63, 63);
		load_point(2, 32767, 32767);
		query_pair(2, 63);
		load_point(3, 0, 0);
		load_point(4, 3, 4);
		query_pair(3, 4);
		load_point(5, -1, -1);
		query_pair(5, 3);
	endtask

	// Query right behind a load of the same entry: the table write lands the
	// cycle before the query reads it.
	task automatic test_load_then_query();
		calm = 1'b1;
		load_point(10, 100, 0);
		query_pair(10, 3);
		load_point(10, -100, 0);
		query_pair(3, 10);
		load_point(10, 0, -7);
		query_pair(10, 10);
		query_pair(10, 4);
		calm = 1'b0;
	endtask

	task automatic test_random_traffic(input int beats, input bit no_gaps);
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		calm = no_gaps;
		for (int n = 0; n < beats; n++) begin
			if ($urandom_range(0, 99) < 35) begin
				load_point(int'(IDX_W'($urandom)), int'(pick_coord()), int'(pick_coord()));
			end else begin
				// one in five queries hits the entry just loaded
				a = ($urandom_range(0, 4) == 0) ? last_loaded : pick_loaded();
				b = ($urandom_range(0, 19) == 0) ? a : pick_loaded();
				if ($urandom_range(0, 1) == 1) begin
					query_pair(int'(a), int'(b));
				end else begin
					query_pair(int'(b), int'(a));
				end
			end
		end
		calm = 1'b0;
	endtask

	// Result side: pop held low for random stretches, high otherwise.
	always @(negedge clk) begin
		if (pop_hold == 0 && !calm && $urandom_range(0, 3) == 0) begin
			pop_hold = pick_gap();
		end
		pop <= (pop_hold == 0);
		if (pop_hold > 0) begin
			pop_hold = pop_hold - 1;
		end
	end

	// Each result beat against the oldest expected distance.
	always @(posedge clk) begin
		if (arst_n && out_beat) begin
			if (dist_expected.size() == 0) begin
				$display("%0t: unexpected result beat, distance %0d", $time, distance);
				mismatches++;
			end else if (distance !== dist_expected[0]) begin
				$display("%0t: distance mismatch, expected %0d actual %0d",
					$time, dist_expected[0], distance);
				mismatches++;
				void'(dist_expected.pop_front());
			end else begin
				void'(dist_expected.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || in_beat || out_beat) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results outstanding",
				$time, idle_cycles, dist_expected.size());
			$display("tb_euclidean_distance_table: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_corner_points();
		test_self_and_overlap();
		test_load_then_query();
		test_random_traffic(1200, 1'b0);
		test_random_traffic(375, 1'b1);

		@(negedge clk);
		push <= 1'b0;
		while (dist_expected.size() != 0) begin
			@(posedge clk);
		end
		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_euclidean_distance_table: clean");
		end else begin
			$display("tb_euclidean_distance_table: errors");
		end
		$finish;
	end

endmodule
